>>> rtl/gha_pkg.sv
package gha_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int IdxW       = $clog2(SLOT_COUNT);
    localparam int SlotW      = IdxW + 1;
    localparam logic [SlotW-1:0] NoSlot = {SlotW{1'b1}};

    typedef enum logic [1:0] {
        OP_CREATE    = 2'd0,
        OP_CREATE_ID = 2'd1,
        OP_DESTROY   = 2'd2,
        OP_QUERY     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_ALIVE = 2'd1,
        ST_COLLIDE   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0] opcode;
        logic [9:0] handle_index;
        logic [7:0] handle_version;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  out_index;
        logic [7:0]  out_version;
        logic [10:0] live_count;
    } t_out;

    typedef struct packed {
        logic [7:0]       version;
        logic             alive;
        logic [SlotW-1:0] next_free;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic fill;
        logic rd;
        logic exec;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic need_fill;
        logic fill_last;
        logic out_free;
    } t_sts;

endpackage

>>> rtl/gha_ram.sv
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/gha_ctrl.sv
module gha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  gha_pkg::t_sts i_sts,
    output gha_pkg::t_cmd o_cmd
);
    import gha_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FILL = 4'b0010,
        S_RD   = 4'b0100,
        S_EX   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = i_sts.need_fill ? S_FILL : S_EX;
                end
            end
            S_FILL: begin
                o_cmd.fill = 1'b1;
                if (i_sts.fill_last) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EX;
            end
            S_EX: begin
                // hold until the result register can take the item
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/gha_dp.sv
module gha_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gha_pkg::t_in  i_in,
    input  gha_pkg::t_cmd i_cmd,
    output gha_pkg::t_sts o_sts,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output gha_pkg::t_out o_out
);
    import gha_pkg::*;

    t_in              r_item;
    logic [SlotW-1:0] r_head;
    logic [SlotW-1:0] r_used;
    logic [SlotW-1:0] r_alive;
    logic             r_out_valid;
    t_out             r_out;

    logic [SlotW-1:0] n_head;
    logic [SlotW-1:0] n_used;
    logic [SlotW-1:0] n_alive;
    t_out             n_out;

    t_entry           rd_entry;
    logic [$bits(t_entry)-1:0] ram_rdata;
    logic             ram_we;
    logic [IdxW-1:0]  ram_waddr;
    t_entry           ram_wdata;
    logic             ram_re;
    logic [IdxW-1:0]  ram_raddr;

    logic             ex_we;
    logic [IdxW-1:0]  ex_waddr;
    t_entry           ex_wdata;

    logic [SlotW-1:0] idx_ext;
    logic [SlotW-1:0] in_idx_ext;
    logic             head_ok;
    logic             used_full;
    logic             oob;
    logic             live;
    logic             take_head;
    logic [7:0]       bumped;

    assign rd_entry   = t_entry'(ram_rdata);
    assign idx_ext    = SlotW'(r_item.handle_index);
    assign in_idx_ext = SlotW'(i_in.handle_index);
    assign head_ok    = r_head < r_used;
    assign used_full  = r_used >= SlotW'(SLOT_COUNT);
    assign oob        = idx_ext >= SlotW'(SLOT_COUNT);
    assign live       = (idx_ext < r_used) && rd_entry.alive
                        && (rd_entry.version == r_item.handle_version);
    assign bumped     = (rd_entry.version == 8'hFF) ? 8'd1 : rd_entry.version + 8'd1;

    assign o_sts.need_fill = (i_in.opcode == OP_CREATE_ID) && (in_idx_ext >= r_used)
                             && (in_idx_ext < SlotW'(SLOT_COUNT));
    assign o_sts.fill_last = r_used == idx_ext;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // read port: issued on accept, or after a fill run
    always_comb begin
        ram_re = i_cmd.accept || i_cmd.rd;
        if (i_cmd.accept) begin
            ram_raddr = (i_in.opcode == OP_CREATE) ? r_head[IdxW-1:0]
                                                   : i_in.handle_index[IdxW-1:0];
        end else begin
            ram_raddr = r_item.handle_index[IdxW-1:0];
        end
    end

    // execute step: decide on the fetched entry
    always_comb begin
        n_head            = r_head;
        n_used            = r_used;
        n_alive           = r_alive;
        ex_we             = 1'b0;
        ex_waddr          = r_item.handle_index[IdxW-1:0];
        ex_wdata          = '{version: r_item.handle_version, alive: 1'b1,
                              next_free: NoSlot};
        take_head         = 1'b0;
        n_out.status      = ST_OK;
        n_out.out_index   = r_item.handle_index;
        n_out.out_version = r_item.handle_version;
        case (r_item.opcode)
            OP_CREATE: begin
                if (head_ok) begin
                    n_head    = rd_entry.next_free;
                    take_head = !rd_entry.alive;
                end else begin
                    n_head = NoSlot;
                end
                if (take_head) begin
                    ex_we            = 1'b1;
                    ex_waddr         = r_head[IdxW-1:0];
                    ex_wdata.version = bumped;
                end else if (used_full) begin
                    n_out.status = ST_FULL;
                end else begin
                    ex_we            = 1'b1;
                    ex_waddr         = r_used[IdxW-1:0];
                    ex_wdata.version = 8'd1;
                    n_used           = r_used + 1'b1;
                end
                if (ex_we) begin
                    n_alive = r_alive + 1'b1;
                end
                n_out.out_index   = ex_we ? 10'(ex_waddr) : 10'd0;
                n_out.out_version = ex_we ? ex_wdata.version : 8'd0;
            end
            OP_CREATE_ID: begin
                if (oob) begin
                    n_out.status = ST_FULL;
                end else if (rd_entry.alive) begin
                    n_out.status = (rd_entry.version == r_item.handle_version)
                                   ? ST_OK : ST_COLLIDE;
                end else begin
                    if (r_head == idx_ext) begin
                        n_head = rd_entry.next_free;
                    end
                    ex_we   = 1'b1;
                    n_alive = r_alive + 1'b1;
                end
            end
            OP_DESTROY: begin
                if (live) begin
                    ex_we    = 1'b1;
                    ex_wdata = '{version: rd_entry.version, alive: 1'b0,
                                 next_free: r_head};
                    n_head   = idx_ext;
                    n_alive  = r_alive - 1'b1;
                end else begin
                    n_out.status = ST_NOT_ALIVE;
                end
            end
            default: begin
                n_out.status = live ? ST_OK : ST_NOT_ALIVE;
            end
        endcase
        n_out.live_count = n_alive;
    end

    // write port: filler entries during a fill run, else the execute step
    always_comb begin
        if (i_cmd.fill) begin
            ram_we    = 1'b1;
            ram_waddr = r_used[IdxW-1:0];
            ram_wdata = '{version: 8'd1, alive: 1'b0, next_free: NoSlot};
        end else begin
            ram_we    = i_cmd.exec && ex_we;
            ram_waddr = ex_waddr;
            ram_wdata = ex_wdata;
        end
    end

    gha_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (SLOT_COUNT)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= NoSlot;
            r_used      <= '0;
            r_alive     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fill) begin
                r_used <= r_used + 1'b1;
            end else if (i_cmd.exec) begin
                r_used <= n_used;
            end
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_alive <= n_alive;
            end
            if (i_cmd.exec) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in;
        end
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_alive_le_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alive <= r_used)
        else $error("live count exceeds used slots");

    a_head_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == NoSlot) || (r_head < r_used))
        else $error("free-list head points past used slots");

    a_fill_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (r_used < SlotW'(SLOT_COUNT)) && (r_used <= idx_ext))
        else $error("fill beyond requested slot");

    a_exec_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before taken");

    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> r_out_valid)
        else $error("executed item produced no result");

endmodule

>>> rtl/generational_handle_allocator.sv
// Sequence: accept registers the item and issues the registered slot read;
//   the execute state then commits the slot write and loads the result
//   register. Create-with-id on a slot at or beyond the used count first
//   writes filler slots up to and including it, then re-reads it. Items are
//   accepted only while idle; execute waits for a free result register.
// Reset: synchronous, active low; clears free-list head to empty and the used
//   and live counts to zero. Slot RAM is not cleared and needs no sweep.
module generational_handle_allocator (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  gha_pkg::t_in i_in,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output gha_pkg::t_out o_out
);
    import gha_pkg::*;

    // Controller sequences each item: accept (issue the slot read), an optional
    // fill run plus re-read for create-with-id, then execute, which commits the
    // slot write and loads the result register. The result register decouples
    // the output side, so a new item can be accepted while a result waits.
    t_cmd cmd;
    t_sts sts;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath holds the slot RAM (version, alive flag, free-list link per
    // slot), the free-list head, used-slot count and live count, and
    // the result register.
    gha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

>>> sim/tb_generational_handle_allocator.sv
`timescale 1ns / 100ps

module tb_generational_handle_allocator;
    import gha_pkg::*;

    // Slowest correct run: every item may wait out a sender gap and a receiver
    // stall, plus fill sweeps of the whole table by create-with-id. The cycle
    // limit is set above that run.
    localparam int CycleLimit = 400000;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in        = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;

    generational_handle_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the slot table and its bookkeeping. Entries at or above
    // shadow_used are never read, so they need no reset value.
    logic [7:0]       shadow_version [SLOT_COUNT];
    logic             shadow_alive   [SLOT_COUNT];
    logic [SlotW-1:0] shadow_link    [SLOT_COUNT];
    logic [SlotW-1:0] shadow_head = NoSlot;
    int               shadow_used = 0;
    int               shadow_live = 0;

    t_out        pending_results [$];
    t_out        last_expected;
    int          error_count = 0;
    bit          idle_en     = 1'b0;
    int          stall_left  = 0;
    int unsigned cycle_count = 0;

    // A handle is live only if its slot has been handed out, is alive, and
    // carries the same version.
    function automatic bit shadow_handle_live(int idx, logic [7:0] ver);
        if (idx >= shadow_used || idx >= SLOT_COUNT) return 1'b0;
        return shadow_alive[idx] && shadow_version[idx] == ver;
    endfunction

    // Apply one item to the shadow table and return the result it must produce.
    function automatic t_out apply_handle_op(t_in item);
        t_out       res;
        int         slot;
        int         h;
        int         idx;
        logic [7:0] nv;
        idx             = int'(item.handle_index);
        res.status      = ST_OK;
        res.out_index   = item.handle_index;
        res.out_version = item.handle_version;
        case (t_op'(item.opcode))
            OP_CREATE: begin
                slot = -1;
                nv   = 8'd1;
                // Pop the free-list head; a head that was claimed by a
                // create-with-id while deeper in the list is stale: drop it.
                if (shadow_head < SLOT_COUNT && shadow_head < shadow_used) begin
                    h           = int'(shadow_head);
                    shadow_head = shadow_link[h];
                    if (!shadow_alive[h]) begin
                        slot = h;
                        nv   = shadow_version[h] + 8'd1;
                        if (nv == 8'd0) nv = 8'd1;
                    end
                end else begin
                    shadow_head = NoSlot;
                end
                if (slot < 0 && shadow_used >= SLOT_COUNT) begin
                    res.status      = ST_FULL;
                    res.out_index   = '0;
                    res.out_version = '0;
                end else begin
                    if (slot < 0) begin
                        slot = shadow_used;
                        shadow_used++;
                        nv = 8'd1;
                    end
                    shadow_alive[slot]   = 1'b1;
                    shadow_version[slot] = nv;
                    shadow_link[slot]    = NoSlot;
                    shadow_live++;
                    res.out_index   = slot[IdxW-1:0];
                    res.out_version = nv;
                end
            end
            OP_CREATE_ID: begin
                if (idx >= SLOT_COUNT) begin
                    res.status = ST_FULL;
                end else begin
                    // Fill never-used slots up to the target: version 1, dead,
                    // off the free list.
                    while (shadow_used <= idx) begin
                        shadow_version[shadow_used] = 8'd1;
                        shadow_alive[shadow_used]   = 1'b0;
                        shadow_link[shadow_used]    = NoSlot;
                        shadow_used++;
                    end
                    if (shadow_alive[idx]) begin
                        res.status = (shadow_version[idx] == item.handle_version) ?
                                     ST_OK : ST_COLLIDE;
                    end else begin
                        if (shadow_head == idx) shadow_head = shadow_link[idx];
                        shadow_alive[idx]   = 1'b1;
                        shadow_version[idx] = item.handle_version;
                        shadow_link[idx]    = NoSlot;
                        shadow_live++;
                    end
                end
            end
            OP_DESTROY: begin
                if (!shadow_handle_live(idx, item.handle_version)) begin
                    res.status = ST_NOT_ALIVE;
                end else begin
                    shadow_alive[idx] = 1'b0;
                    shadow_link[idx]  = shadow_head;
                    shadow_head       = idx[SlotW-1:0];
                    shadow_live--;
                end
            end
            default: begin
                res.status = shadow_handle_live(idx, item.handle_version) ?
                             ST_OK : ST_NOT_ALIVE;
            end
        endcase
        res.live_count = shadow_live[10:0];
        return res;
    endfunction

    // Find some live handle, starting the scan at a random used slot.
    function automatic bit pick_live(output logic [9:0] idx, output logic [7:0] ver);
        int start;
        int k;
        int s;
        idx = '0;
        ver = '0;
        if (shadow_live == 0) return 1'b0;
        start = $urandom_range(0, shadow_used - 1);
        for (k = 0; k < shadow_used; k++) begin
            s = (start + k) % shadow_used;
            if (shadow_alive[s]) begin
                idx = s[9:0];
                ver = shadow_version[s];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Mostly well-formed traffic on live handles, with stale, wrong-version
    // and far-away handles mixed in as noise.
    function automatic t_in random_item();
        t_in        it;
        int         r;
        int         sub;
        int         hi;
        bit         got;
        logic [9:0] li;
        logic [7:0] lv;
        it.opcode         = OP_CREATE;
        it.handle_index   = 10'($urandom);
        it.handle_version = 8'($urandom);
        got = pick_live(li, lv);
        r   = $urandom_range(0, 99);
        sub = $urandom_range(0, 99);
        if (r < 28) begin
            it.opcode = OP_CREATE;
        end else if (r < 40) begin
            it.opcode = OP_CREATE_ID;
            hi = shadow_used + 8;
            if (hi > 1023) hi = 1023;
            if (sub < 3) begin
                // keep the full-range index: long fill
            end else if (sub < 40 && got) begin
                it.handle_index = li;
                if (sub < 20) it.handle_version = lv;
            end else begin
                it.handle_index = 10'($urandom_range(0, hi));
            end
            if ($urandom_range(0, 9) == 0)
                it.handle_version = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end else begin
            it.opcode = (r < 72) ? OP_DESTROY : OP_QUERY;
            hi = shadow_used + 4;
            if (hi > 1023) hi = 1023;
            if (sub < 75 && got) begin
                it.handle_index   = li;
                it.handle_version = lv;
                if (sub < 8) it.handle_version = lv + 8'($urandom_range(1, 255));
            end else if (sub < 92) begin
                it.handle_index = 10'($urandom_range(0, hi));
            end
        end
        return it;
    endfunction

    // Present one item, hold it until accepted, then record its result.
    task automatic send_item(input t_in item);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 17);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= item;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        last_expected = apply_handle_op(item);
        pending_results.insert(pending_results.size(), last_expected);
    endtask

    task automatic send_op(input t_op op, input int idx, input int ver);
        t_in it;
        it.opcode         = op;
        it.handle_index   = idx[9:0];
        it.handle_version = ver[7:0];
        send_item(it);
    endtask

    // Walk through every operation and each corner of the free list.
    task automatic test_directed();
        idle_en = 1'b1;
        send_op(OP_QUERY, 0, 0);           // empty table: nothing alive
        send_op(OP_DESTROY, 1023, 255);    // index beyond used slots
        send_op(OP_CREATE, 0, 0);          // fresh slot 0
        send_op(OP_CREATE, 1023, 255);     // fresh slot 1, payload ignored
        send_op(OP_CREATE, 0, 0);          // fresh slot 2
        send_op(OP_QUERY, 1, 1);
        send_op(OP_QUERY, 1, 2);           // wrong version
        send_op(OP_DESTROY, 1, 2);         // wrong version: no change
        send_op(OP_DESTROY, 1, 1);
        send_op(OP_DESTROY, 1, 1);         // already dead
        send_op(OP_CREATE, 0, 0);          // reuse slot 1 with version 2
        send_op(OP_CREATE_ID, 2, 1);       // alive, same version
        send_op(OP_CREATE_ID, 2, 7);       // alive, other version: collision
        send_op(OP_CREATE_ID, 6, 255);     // fill 3..5, claim 6
        send_op(OP_QUERY, 4, 1);           // filled slot stays dead
        send_op(OP_DESTROY, 6, 255);
        send_op(OP_CREATE, 0, 0);          // version wraps past zero to 1
        send_op(OP_DESTROY, 0, 1);
        send_op(OP_DESTROY, 2, 1);         // free list now 2 -> 0
        send_op(OP_CREATE_ID, 0, 0);       // claim slot deep in list, version zero
        send_op(OP_QUERY, 0, 0);
        send_op(OP_CREATE, 0, 0);          // pops 2
        send_op(OP_CREATE, 0, 0);          // stale head 0: drop, take fresh slot
        send_op(OP_DESTROY, 7, 1);
        send_op(OP_CREATE_ID, 7, 42);      // claim the free-list head itself
        send_op(OP_CREATE, 0, 0);          // list empty again: fresh slot
    endtask

    // Random traffic; switch idling off for one stretch in every three.
    task automatic test_random(input int count);
        int n;
        for (n = 0; n < count; n++) begin
            idle_en = ((n / 64) % 3) != 2;
            send_item(random_item());
        end
    endtask

    // Fill the whole table, drain the free list, and hit the full flag.
    task automatic test_table_full();
        int full_seen;
        int guard;
        idle_en   = 1'b1;
        full_seen = 0;
        guard     = 0;
        send_op(OP_CREATE_ID, 1023, int'($urandom_range(0, 255)));
        while (full_seen < 2 && guard < 2200) begin
            send_op(OP_CREATE, int'($urandom), int'($urandom));
            if (last_expected.status == ST_FULL) full_seen++;
            guard++;
        end
        send_op(OP_QUERY, 1023, int'(shadow_version[1023]));
        send_op(OP_DESTROY, 1023, int'(shadow_version[1023]));
        send_op(OP_CREATE, 0, 0);          // reuse 1023
        send_op(OP_CREATE, 0, 0);          // full again
        send_op(OP_QUERY, 1023, int'(shadow_version[1023]) + 1);
    endtask

    // Back-to-back traffic with no idling on either side.
    task automatic test_streaming(input int count);
        int n;
        idle_en = 1'b0;
        for (n = 0; n < count; n++) send_item(random_item());
    endtask

    // Receiver: drop ready for random stretches while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 16);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: status %0d index %0d",
                       o_out.status, o_out.out_index);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out.status);
                    error_count++;
                end
                if (o_out.out_index !== want.out_index) begin
                    $error("out_index: expected %0d, got %0d",
                           want.out_index, o_out.out_index);
                    error_count++;
                end
                if (o_out.out_version !== want.out_version) begin
                    $error("out_version: expected %0d, got %0d",
                           want.out_version, o_out.out_version);
                    error_count++;
                end
                if (o_out.live_count !== want.live_count) begin
                    $error("live_count: expected %0d, got %0d",
                           want.live_count, o_out.live_count);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("tb_generational_handle_allocator: errors");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(420);
        test_table_full();
        test_streaming(64);
        i_in_valid <= 1'b0;
        // Drain outstanding results, then leave room for any stray item.
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("tb_generational_handle_allocator: clean");
        end else begin
            $display("tb_generational_handle_allocator: errors");
        end
        $finish;
    end

endmodule
